[sv/tkh_pkg.sv]
// Shared command codes and status types for the top-k min-heap selector.
`default_nettype none

package tkh_pkg;

    // Datapath command issued by the controller each cycle
    typedef logic [3:0] t_op;

    localparam t_op OP_NONE       = 4'd0;
    localparam t_op OP_ACCEPT     = 4'd1;   // latch input beat
    localparam t_op OP_APPEND     = 4'd2;   // store value at fill, fill++
    localparam t_op OP_BUILD_INIT = 4'd3;   // build index = (k-1)/2
    localparam t_op OP_BUILD_NEXT = 4'd4;   // build index--
    localparam t_op OP_RD_NODE    = 4'd5;   // read heap[node]
    localparam t_op OP_LD_CUR     = 4'd6;   // cur = read data
    localparam t_op OP_RD_ROOT    = 4'd7;   // read heap[0]
    localparam t_op OP_ROOT_INIT  = 4'd8;   // node = 0, cur = new value
    localparam t_op OP_RD_L       = 4'd9;   // read left child, or park cur
    localparam t_op OP_RD_R       = 4'd10;  // compare left, read right child
    localparam t_op OP_CMP        = 4'd11;  // compare right, move one level
    localparam t_op OP_EM_INIT    = 4'd12;  // emit index = 0
    localparam t_op OP_EM_RD      = 4'd13;  // read heap[emit index]
    localparam t_op OP_EM_LD      = 4'd14;  // load output register

    // Status from datapath to controller
    typedef struct packed {
        logic fill_lt_k;    // store not yet full
        logic fill_hit_k;   // this append fills the store
        logic v_gt_root;    // new value beats the root (read data)
        logic l_ok;         // left child inside heap
        logic swap;         // smaller child beats the moving value
        logic bi_zero;      // build reached the root
        logic em_final;     // emit index is the final entry
        logic out_free;     // output register free or draining now
        logic last;         // latched beat was marked last
    } t_stat;

endpackage

`default_nettype wire

[sv/tkh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tkh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/tkh_ctrl.sv]
// Sequencer of the top-k selector: append, heap build, sift-down and emit.
`default_nettype none

module tkh_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire tkh_pkg::t_stat i_stat,
    output tkh_pkg::t_op       o_op
);
    import tkh_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_BINIT = 4'd2;
    localparam logic [3:0] ST_RDN   = 4'd3;
    localparam logic [3:0] ST_LDN   = 4'd4;
    localparam logic [3:0] ST_ROOT  = 4'd5;
    localparam logic [3:0] ST_RDL   = 4'd6;
    localparam logic [3:0] ST_RDR   = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_SDONE = 4'd9;
    localparam logic [3:0] ST_CHK   = 4'd10;
    localparam logic [3:0] ST_EMRD  = 4'd11;
    localparam logic [3:0] ST_EMLD  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_build, n_build;   // sift belongs to the bottom-up build

    // next state and command
    always_comb begin
        n_state = r_state;
        n_build = r_build;
        o_op    = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_op    = OP_ACCEPT;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_stat.fill_lt_k) begin
                    o_op    = OP_APPEND;
                    n_state = i_stat.fill_hit_k ? ST_BINIT : ST_CHK;
                end else begin
                    o_op    = OP_RD_ROOT;
                    n_state = ST_ROOT;
                end
            end
            ST_BINIT: begin
                o_op    = OP_BUILD_INIT;
                n_build = 1'b1;
                n_state = ST_RDN;
            end
            ST_RDN: begin
                o_op    = OP_RD_NODE;
                n_state = ST_LDN;
            end
            ST_LDN: begin
                o_op    = OP_LD_CUR;
                n_state = ST_RDL;
            end
            ST_ROOT: begin
                n_build = 1'b0;
                if (i_stat.v_gt_root) begin
                    o_op    = OP_ROOT_INIT;
                    n_state = ST_RDL;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_RDL: begin
                o_op    = OP_RD_L;
                n_state = i_stat.l_ok ? ST_RDR : ST_SDONE;
            end
            ST_RDR: begin
                o_op    = OP_RD_R;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_op    = OP_CMP;
                n_state = i_stat.swap ? ST_RDL : ST_SDONE;
            end
            ST_SDONE: begin
                if (r_build && !i_stat.bi_zero) begin
                    o_op    = OP_BUILD_NEXT;
                    n_state = ST_RDN;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.last) begin
                    o_op    = OP_EM_INIT;
                    n_state = ST_EMRD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMRD: begin
                if (i_stat.out_free) begin
                    o_op    = OP_EM_RD;
                    n_state = ST_EMLD;
                end
            end
            ST_EMLD: begin
                o_op    = OP_EM_LD;
                n_state = i_stat.em_final ? ST_IDLE : ST_EMRD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_build <= 1'b0;
        end else begin
            r_state <= n_state;
            r_build <= n_build;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

[sv/tkh_dp.sv]
// Datapath of the top-k selector: heap RAM, sift registers, fill count, output.
`default_nettype none

module tkh_dp #(
    parameter int K_MAX = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [4:0]    i_cfg_data,
    input  wire logic [31:0]   i_s_tdata,
    input  wire logic          i_s_tlast,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [31:0]        o_m_tdata,
    output logic               o_m_tlast,
    input  wire tkh_pkg::t_op  i_op,
    output tkh_pkg::t_stat     o_stat
);
    import tkh_pkg::*;

    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;   // heap index
    localparam int FW = $clog2(K_MAX + 1);                 // fill count
    localparam int CW = AW + 2;                            // child index
    localparam int KW = (FW > 5) ? FW : 5;

    logic [4:0]         r_cfg;
    logic [FW-1:0]      r_fill;
    logic signed [31:0] r_v;
    logic               r_last;
    logic signed [31:0] r_cur;      // value being sifted down
    logic signed [31:0] r_best;     // smaller of cur and left child
    logic [AW-1:0]      r_bidx;
    logic               r_rv;       // right child inside heap
    logic [AW-1:0]      r_node;
    logic [AW-1:0]      r_bi;       // build index
    logic [AW-1:0]      r_ei;       // emit index
    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic               r_out_last;

    logic [KW-1:0]      cfg_x;
    logic [FW-1:0]      k_eff;
    logic [CW-1:0]      l_idx, r_idx;
    logic               l_ok, r_ok;
    logic signed [31:0] rd_s;
    logic [31:0]        rdata;
    logic signed [31:0] best2;
    logic [AW-1:0]      m_idx;
    logic               swap;
    logic               em_final;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata;

    // effective k: zero reads as one, clamp at K_MAX
    always_comb begin
        cfg_x = KW'(r_cfg);
        if (cfg_x == '0) begin
            k_eff = FW'(1);
        end else if (cfg_x > KW'(K_MAX)) begin
            k_eff = FW'(K_MAX);
        end else begin
            k_eff = cfg_x[FW-1:0];
        end
    end

    // child indexes of the current node
    assign l_idx = {1'b0, r_node, 1'b1};
    assign r_idx = l_idx + CW'(1);
    assign l_ok  = l_idx < CW'(r_fill);
    assign r_ok  = r_idx < CW'(r_fill);
    assign rd_s  = $signed(rdata);

    // right child step: smaller child wins, ties keep the earlier pick
    always_comb begin
        if (r_rv && (r_best > rd_s)) begin
            best2 = rd_s;
            m_idx = r_idx[AW-1:0];
        end else begin
            best2 = r_best;
            m_idx = r_bidx;
        end
    end
    assign swap     = (m_idx != r_node);
    assign em_final = ((FW'(r_ei) + FW'(1)) == r_fill);

    // RAM port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_node;
        wdata = r_cur;
        raddr = r_node;
        unique case (i_op)
            OP_APPEND: begin
                we    = 1'b1;
                waddr = r_fill[AW-1:0];
                wdata = r_v;
            end
            OP_RD_ROOT: raddr = '0;
            OP_RD_L: begin
                raddr = l_idx[AW-1:0];
                we    = !l_ok;
            end
            OP_RD_R: raddr = r_idx[AW-1:0];
            OP_CMP: begin
                we    = 1'b1;
                wdata = swap ? best2 : r_cur;
            end
            OP_EM_RD: raddr = r_ei;
            default: ;
        endcase
    end

    tkh_ram #(
        .WIDTH (32),
        .DEPTH (K_MAX),
        .AW    (AW)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= 5'd8;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_op == OP_APPEND) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_op == OP_EM_LD && em_final) begin
                r_fill <= '0;
            end
            if (i_op == OP_EM_LD) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_ACCEPT: begin
                r_v    <= $signed(i_s_tdata);
                r_last <= i_s_tlast;
            end
            OP_BUILD_INIT: begin
                r_bi   <= AW'((k_eff - FW'(1)) >> 1);
                r_node <= AW'((k_eff - FW'(1)) >> 1);
            end
            OP_BUILD_NEXT: begin
                r_bi   <= r_bi - AW'(1);
                r_node <= r_bi - AW'(1);
            end
            OP_LD_CUR: r_cur <= rd_s;
            OP_ROOT_INIT: begin
                r_node <= '0;
                r_cur  <= r_v;
            end
            OP_RD_R: begin
                if (r_cur > rd_s) begin
                    r_best <= rd_s;
                    r_bidx <= l_idx[AW-1:0];
                end else begin
                    r_best <= r_cur;
                    r_bidx <= r_node;
                end
                r_rv <= r_ok;
            end
            OP_CMP: r_node <= m_idx;
            OP_EM_INIT: r_ei <= '0;
            OP_EM_LD: begin
                r_out_data <= rdata;
                r_out_last <= em_final;
                r_ei       <= r_ei + AW'(1);
            end
            default: ;
        endcase
    end

    // status to controller
    always_comb begin
        o_stat.fill_lt_k  = r_fill < k_eff;
        o_stat.fill_hit_k = (r_fill + FW'(1)) == k_eff;
        o_stat.v_gt_root  = r_v > rd_s;
        o_stat.l_ok       = l_ok;
        o_stat.swap       = swap;
        o_stat.bi_zero    = (r_bi == '0);
        o_stat.em_final   = em_final;
        o_stat.out_free   = !r_out_valid || i_m_tready;
        o_stat.last       = r_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

[sv/top_k_min_heap_selector.sv]
// A beat that only fills the store is accepted and appended; a full store adds a root read
// and, per heap level of sift-down, a left read, a right read and a compare; the bottom-up
// build reads, loads and sifts down each node from (k-1)/2 down to the root.
// Throughput: one beat at a time, paced by the single read port of the heap RAM.
// A last beat then emits the kept values, a read and a load each, stalled by i_m_tready.
// Reset (synchronous, active low) empties the store and sets keep_count to 8.
`default_nettype none

module top_k_min_heap_selector #(
    parameter int K_MAX = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,   // keep_count
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,    // [31:0] value (signed)
    input  wire logic        i_s_tlast,    // last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,    // [31:0] kept_value (signed)
    output logic             o_m_tlast     // last_out
);
    import tkh_pkg::*;

    t_op   op;
    t_stat stat;

    tkh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    tkh_dp #(
        .K_MAX (K_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_op       (op),
        .o_stat     (stat)
    );

endmodule

`default_nettype wire

[sv/tkh_chk.sv]
// Port-level checks of the top-k selector, bound to the top level.
`default_nettype none

module tkh_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // one input beat at a time
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while previous beat in work");

    // reset leaves no output pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // only the final beat of a run may wait while the block is idle
    a_idle_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && o_m_tvalid |-> o_m_tlast)
        else $error("idle with a non-final output beat pending");

endmodule

bind top_k_min_heap_selector tkh_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the top-k min-heap selector, checked against a heap predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int K_MAX      = 16;
    localparam int SETTLE     = 200;      // worst bottom-up build plus a sift, with margin
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 205;

    // One input beat and one kept-value beat
    typedef struct {
        logic [31:0] value;
        logic        last;
    } t_sample;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } t_kept_beat;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [4:0]  cfg_data = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    t_sample    sample_q[$];     // beats waiting to be sent
    t_kept_beat kept_q[$];       // kept values still owed by the block

    // Predictor state: the heap array, its fill and the keep count
    logic signed [31:0] heap_m[K_MAX];
    int                 fill_m   = 0;
    logic [4:0]         keep_m   = 5'd8;

    int   errors    = 0;
    int   cycles    = 0;
    logic in_taken  = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   rx_mode    = 0;
    int   rx_span    = 0;

    top_k_min_heap_selector #(.K_MAX(K_MAX)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Min-heap sift-down: ties keep the parent, the left child wins on equality
    function automatic void sift_min(int size, int node);
        int l;
        int r;
        int m;
        bit done;
        logic signed [31:0] t;
        done = 1'b0;
        while (node < size && !done) begin
            l = 2 * node + 1;
            r = l + 1;
            m = node;
            if (l < size && heap_m[m] > heap_m[l]) m = l;
            if (r < size && heap_m[m] > heap_m[r]) m = r;
            if (m == node) begin
                done = 1'b1;
            end else begin
                t            = heap_m[m];
                heap_m[m]    = heap_m[node];
                heap_m[node] = t;
                node         = m;
            end
        end
    endfunction

    // Fold one accepted beat into the heap; a last beat queues the kept values
    function automatic void absorb_sample(logic [31:0] v, logic last);
        int k;
        int i;
        t_kept_beat b;
        k = (keep_m == 5'd0) ? 1 : (keep_m > K_MAX) ? K_MAX : int'(keep_m);
        if (fill_m < k) begin
            heap_m[fill_m] = v;
            fill_m++;
            if (fill_m == k) begin
                for (i = (k - 1) / 2; i >= 0; i--) sift_min(k, i);
            end
        end else if (fill_m > 0 && $signed(v) > heap_m[0]) begin
            heap_m[0] = v;
            sift_min(fill_m, 0);
        end
        if (last) begin
            for (i = 0; i < fill_m; i++) begin
                b.value = heap_m[i];
                b.last  = (i + 1 == fill_m);
                kept_q.push_back(b);
            end
            fill_m = 0;
        end
    endfunction

    // Monitor: check the output beat first, then fold in the input beat and config
    always @(posedge clk) begin
        t_kept_beat want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (kept_q.size() == 0) begin
                    $error("unexpected beat: kept_value %0d last_out %0b",
                           $signed(m_tdata), m_tlast);
                    errors++;
                end else begin
                    want = kept_q.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("kept_value: expected %0d, got %0d",
                               want.value, $signed(m_tdata));
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) absorb_sample(s_tdata, s_tlast);
            if (cfg_we) keep_m = cfg_data;
        end
    end

    // Driver: bursts of beats with random gaps between them
    always @(negedge clk) begin
        t_sample next;
        if (rst_n && (in_taken || !s_tvalid)) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                next = sample_q.pop_front();
                s_tdata  <= next.value;
                s_tlast  <= next.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches at random between four modes, from always ready to rarely ready
    always @(negedge clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_span <= $urandom_range(20, 120);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value(int style);
        case (style)
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            2: begin
                return int'($urandom_range(0, 6)) - 3;     // dense ties
            end
            3: begin
                if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 3);
                return 32'h7fff_ffff - $urandom_range(0, 3);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic push_sample(logic [31:0] v, logic last);
        t_sample s;
        s.value = v;
        s.last  = last;
        sample_q.push_back(s);
    endtask

    // Queue n beats; closing marks the final one last
    task automatic queue_run(int n, int style, bit closing);
        int i;
        for (i = 0; i < n; i++) push_sample(pick_value(style), closing && (i == n - 1));
    endtask

    // Hold the sender until the block has drained every owed result
    task automatic wait_drained();
        while (!(sample_q.size() == 0 && !s_tvalid && kept_q.size() == 0)) @(posedge clk);
    endtask

    task automatic write_keep(logic [4:0] k);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= k;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [31:0] opening[10];
        logic [4:0]  cur_keep;
        int          sent;
        int          eff;
        int          len;
        int          split;
        int          style;
        int          i;
        opening = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'd5,
                    32'd5, -32'sd7, 32'd3, 32'h7fff_ffff, 32'h8000_0000};
        sent = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset keep count of 8: extremes, ties, build on the 8th beat, then replacements
        for (i = 0; i < 10; i++) push_sample(opening[i], i == 9);
        write_keep(5'd1);
        queue_run(3, 1, 1'b1);
        // Zero is taken as one
        write_keep(5'd0);
        queue_run(2, 0, 1'b1);
        // Above the maximum is clipped, and a short set comes out in arrival order
        write_keep(5'd31);
        queue_run(3, 0, 1'b1);
        // Keep count lowered mid-set below the fill: unbuilt store used as a heap
        write_keep(5'd4);
        queue_run(3, 0, 1'b0);
        write_keep(5'd2);
        queue_run(2, 2, 1'b1);
        cur_keep = 5'd2;

        // Random sets, mostly full heaps, some short ones, some with a mid-set change
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 7))
                    0: cur_keep = 5'd0;
                    1: cur_keep = 5'd1;
                    2: cur_keep = 5'd16;
                    3: cur_keep = 5'(17 + $urandom_range(0, 14));
                    default: cur_keep = 5'($urandom_range(1, 16));
                endcase
                write_keep(cur_keep);
            end
            eff = (cur_keep == 5'd0) ? 1 : (cur_keep > K_MAX) ? K_MAX : int'(cur_keep);
            case ($urandom_range(0, 9))
                0, 1: len = $urandom_range(1, eff);
                2: len = eff;
                default: len = eff + $urandom_range(1, 2 * eff);
            endcase
            style = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            if (len >= 2 && $urandom_range(0, 5) == 0) begin
                split = $urandom_range(1, len - 1);
                queue_run(split, style, 1'b0);
                cur_keep = $urandom_range(0, 1) ? 5'($urandom_range(1, 16)) : 5'($urandom);
                write_keep(cur_keep);
                queue_run(len - split, style, 1'b1);
            end else begin
                queue_run(len, style, 1'b1);
            end
            sent += len;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[top_k_min_heap_selector.f]
sv/tkh_pkg.sv
sv/tkh_ram.sv
sv/tkh_ctrl.sv
sv/tkh_dp.sv
sv/top_k_min_heap_selector.sv
sv/tkh_chk.sv
bench/tb_top.sv
